/* hdl/assert_macros.svh */
// Assertion macros for the top-level RTL file of the link packet receiver.
// No dependencies; take in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that prop holds at every rising edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Check that cond is never true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* hdl/lpr_pkg.sv */
// Types and constants of the link packet receiver.
// No dependencies; used by lpr_fsm, link_packet_receiver and the testbench.
package lpr_pkg;

  typedef enum logic [1:0] {
    ST_BUSY    = 2'd0,
    ST_DONE    = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_MISSES  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_HANDSHAKE = 2'd0,
    REG_MAX_MISS  = 2'd1,
    REG_SEED      = 2'd2
  } reg_idx_t;

  localparam logic [7:0]  HANDSHAKE_RST = 8'hAA;
  localparam logic [4:0]  MAX_MISS_RST  = 5'd20;
  localparam logic [31:0] SEED_RST      = 32'hFADEBABE;
  localparam logic [7:0]  TX_IDLE       = 8'h00;
  localparam logic [7:0]  TX_LENGTH     = 8'hFF;

  typedef struct packed {
    logic [7:0]  handshake;
    logic [4:0]  max_miss;
    logic [31:0] seed;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  tx_next;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    status_t     packet_status;
    logic [8:0]  packet_length;
    logic [31:0] packet_checksum;
  } res_t;

endpackage

/* hdl/lpr_fsm.sv */
// Packet phase state machine: holds phase, miss count, length, position and
// running checksum, and forms the result of one item. Depends on lpr_pkg.
module lpr_fsm (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic [7:0]    rx_byte,
  input  logic          rx_timeout,
  input  lpr_pkg::cfg_t cfg,
  output lpr_pkg::res_t res
);
  import lpr_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_ECHO    = 2'd1,
    PH_LENGTH  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  miss_r, miss_nxt, miss_inc;
  logic [8:0]  len_r, len_nxt;
  logic [8:0]  pos_r, pos_nxt, pos_inc;
  logic [31:0] sum_r, sum_nxt, sum_mix;

  assign miss_inc = miss_r + 5'd1;
  assign pos_inc  = pos_r + 9'd1;
  assign sum_mix  = {sum_r[28:0], 3'b000} | ({29'd0, sum_r[31:29]} ^ {24'd0, rx_byte});

  always_comb begin
    phase_nxt = phase_r;
    miss_nxt  = miss_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    res       = '0;
    res.tx_next       = TX_IDLE;
    res.packet_status = ST_BUSY;
    if (rx_timeout) begin
      res.packet_status = ST_TIMEOUT;
      phase_nxt = PH_WAIT;
      miss_nxt  = '0;
    end else begin
      unique case (phase_r)
        PH_WAIT: begin
          if (rx_byte == cfg.handshake) begin
            sum_nxt   = cfg.seed;
            miss_nxt  = '0;
            phase_nxt = PH_ECHO;
            res.tx_next = cfg.handshake;
          end else if (miss_inc >= cfg.max_miss || miss_inc == 5'd0) begin
            res.packet_status = ST_MISSES;
            miss_nxt = '0;
          end else begin
            miss_nxt = miss_inc;
          end
        end
        PH_ECHO: begin
          phase_nxt   = PH_LENGTH;
          res.tx_next = TX_LENGTH;
        end
        PH_LENGTH: begin
          len_nxt   = {1'b0, rx_byte} + 9'd1;
          pos_nxt   = '0;
          phase_nxt = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          res.payload_valid = 1'b1;
          res.payload_byte  = rx_byte;
          res.payload_index = pos_r[7:0];
          sum_nxt = sum_mix;
          pos_nxt = pos_inc;
          if (pos_inc >= len_r || pos_inc == 9'd0) begin
            res.packet_status   = ST_DONE;
            res.packet_length   = len_r;
            res.packet_checksum = sum_mix;
            phase_nxt = PH_WAIT;
            miss_nxt  = '0;
          end else begin
            res.tx_next = pos_inc[7:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      miss_r  <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      sum_r   <= SEED_RST;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      miss_r  <= miss_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

/* hdl/link_packet_receiver.sv */
// Top level of the link packet receiver: input register, configuration
// registers and result register around lpr_fsm. Depends on lpr_pkg, lpr_fsm and assert_macros.svh.
//
// Receive side of a full-duplex byte link. Each input item is the byte of one
// completed transfer (or a timeout flag); each result item is the byte to load
// for the next transfer, plus payload, status, length and checksum fields.
// Exactly one result item leaves for every input item, in order. The block
// takes one item per cycle while results are taken. An item waits in the
// input register, where the phase logic in lpr_fsm evaluates it, until it
// advances and its result is loaded into the result register. The input
// register can take a new item while a finished result waits, if it is empty.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// and are meant for idle periods; a new checksum seed is loaded at
// the next handshake. Writes to an index beyond the register list are dropped.
`include "assert_macros.svh"
module link_packet_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_rx_timeout,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_next,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_payload_index,
  output logic [1:0]  out_packet_status,
  output logic [8:0]  out_packet_length,
  output logic [31:0] out_packet_checksum,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import lpr_pkg::*;

  // configuration registers
  cfg_t cfg_r;

  // input register: holds the item being evaluated
  logic       stg_valid_r;
  logic [7:0] stg_rx_r;
  logic       stg_to_r;

  // result register
  logic out_valid_r;
  res_t res_r;
  res_t res_comb;

  logic adv;

  // advance the staged item when the result register is free or draining
  assign adv      = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.handshake <= HANDSHAKE_RST;
      cfg_r.max_miss  <= MAX_MISS_RST;
      cfg_r.seed      <= SEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HANDSHAKE: cfg_r.handshake <= cfg_data[7:0];
        REG_MAX_MISS:  cfg_r.max_miss  <= cfg_data[4:0];
        REG_SEED:      cfg_r.seed      <= cfg_data;
        default: ;     // drop writes beyond the register list
      endcase
    end
  end

  // capture a new item whenever the input register is empty or advancing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_rx_r <= in_rx_byte;
      stg_to_r <= in_rx_timeout;
    end
  end

  lpr_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (adv),
    .rx_byte    (stg_rx_r),
    .rx_timeout (stg_to_r),
    .cfg        (cfg_r),
    .res        (res_comb)
  );

  // load the result on advance, clear valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_comb;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_tx_next         = res_r.tx_next;
  assign out_payload_valid   = res_r.payload_valid;
  assign out_payload_byte    = res_r.payload_byte;
  assign out_payload_index   = res_r.payload_index;
  assign out_packet_status   = res_r.packet_status;
  assign out_packet_length   = res_r.packet_length;
  assign out_packet_checksum = res_r.packet_checksum;

  `ASSERT_HOLDS(a_adv_loads, clk, rst_n, adv |=> out_valid_r)
  `ASSERT_HOLDS(a_stall_cause, clk, rst_n, !in_ready |-> (stg_valid_r && out_valid_r && !out_ready))
  `ASSERT_HOLDS(a_done_payload, clk, rst_n, (out_valid_r && res_r.packet_status == ST_DONE) |-> res_r.payload_valid)
  `ASSERT_HOLDS(a_len_zero, clk, rst_n, (out_valid_r && res_r.packet_status != ST_DONE) |-> (res_r.packet_length == 9'd0 && res_r.packet_checksum == 32'd0))
  `ASSERT_NEVER(a_idle_payload, clk, rst_n, out_valid_r && !res_r.payload_valid && (res_r.payload_byte != 8'd0 || res_r.payload_index != 8'd0))

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for link_packet_receiver: drives byte transfers and
// timeouts, predicts every reply in a scoreboard class. Depends on lpr_pkg and link_packet_receiver.
`timescale 1ns / 1ps
module testbench;
  import lpr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 4;    // two-register pipeline plus margin
  localparam int          LONG_HOLD     = 80;   // sink stall long enough to back up the input
  localparam int          PHASE_ITEMS   = 310;
  localparam int          NUM_PHASES    = 6;
  localparam logic [1:0]  REG_SPARE     = 2'd3; // index past the register list

  typedef enum logic [1:0] {RX_WAIT, RX_ECHO, RX_LENGTH, RX_PAYLOAD} rx_phase_t;

  // Scoreboard: a private copy of the receiver state and registers; every
  // accepted transfer yields exactly one predicted reply, checked in order.
  class reply_tracker;
    logic [7:0]  hs_value;
    logic [4:0]  miss_limit;
    logic [31:0] seed;
    rx_phase_t   phase;
    logic [4:0]  misses;
    logic [8:0]  pkt_len;
    logic [8:0]  pos;
    logic [31:0] sum;
    res_t        replies_due[$];
    int          mismatches;
    int          replies_seen;

    function new();
      hs_value     = HANDSHAKE_RST;
      miss_limit   = MAX_MISS_RST;
      seed         = SEED_RST;
      phase        = RX_WAIT;
      misses       = '0;
      pkt_len      = '0;
      pos          = '0;
      sum          = SEED_RST;
      mismatches   = 0;
      replies_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_HANDSHAKE: hs_value = data[7:0];
        REG_MAX_MISS:  miss_limit = data[4:0];
        REG_SEED:      seed = data;
        default: ;
      endcase
    endfunction

    function void accept_transfer(logic [7:0] rx, logic timed_out);
      res_t r;
      r = '0;
      r.tx_next = TX_IDLE;
      r.packet_status = ST_BUSY;
      if (timed_out) begin
        r.packet_status = ST_TIMEOUT;
        phase = RX_WAIT;
        misses = '0;
      end else begin
        case (phase)
          RX_WAIT: begin
            if (rx == hs_value) begin
              sum = seed;
              misses = '0;
              phase = RX_ECHO;
              r.tx_next = hs_value;
            end else begin
              misses = misses + 5'd1;
              if (misses >= miss_limit || misses == '0) begin
                r.packet_status = ST_MISSES;
                misses = '0;
              end
            end
          end
          RX_ECHO: begin
            phase = RX_LENGTH;
            r.tx_next = TX_LENGTH;
          end
          RX_LENGTH: begin
            pkt_len = {1'b0, rx} + 9'd1;
            pos = '0;
            phase = RX_PAYLOAD;
          end
          default: begin
            r.payload_valid = 1'b1;
            r.payload_byte = rx;
            r.payload_index = pos[7:0];
            sum = (sum << 3) | ((sum >> 29) ^ {24'd0, rx});
            pos = pos + 9'd1;
            if (pos >= pkt_len || pos == '0) begin
              r.packet_status = ST_DONE;
              r.packet_length = pkt_len;
              r.packet_checksum = sum;
              phase = RX_WAIT;
              misses = '0;
            end else begin
              r.tx_next = pos[7:0];
            end
          end
        endcase
      end
      replies_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply %0d: %s expected 0x%0h, got 0x%0h", replies_seen, name, want, got);
      end
    endfunction

    function void check_reply(res_t got);
      res_t want;
      replies_seen++;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply %0d arrived with nothing outstanding", replies_seen);
        return;
      end
      want = replies_due.pop_front();
      compare_field("tx_next", want.tx_next, got.tx_next);
      compare_field("payload_valid", want.payload_valid, got.payload_valid);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_index", want.payload_index, got.payload_index);
      compare_field("packet_status", want.packet_status, got.packet_status);
      compare_field("packet_length", want.packet_length, got.packet_length);
      compare_field("packet_checksum", want.packet_checksum, got.packet_checksum);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        in_rx_timeout = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_tx_next;
  logic        out_payload_valid;
  logic [7:0]  out_payload_byte;
  logic [7:0]  out_payload_index;
  logic [1:0]  out_packet_status;
  logic [8:0]  out_packet_length;
  logic [31:0] out_packet_checksum;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data = 32'd0;

  reply_tracker sb = new();
  int           items_sent = 0;
  int           tx_idle_pct = 0;   // chance per item that the sender inserts a gap
  int           rx_idle_pct = 0;   // chance per cycle that the sink starts a stall
  int           holds_requested = 0;
  int unsigned  cycles = 0;

  always #10 clk = ~clk;

  link_packet_receiver dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .in_rx_timeout      (in_rx_timeout),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tx_next        (out_tx_next),
    .out_payload_valid  (out_payload_valid),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_packet_status  (out_packet_status),
    .out_packet_length  (out_packet_length),
    .out_packet_checksum(out_packet_checksum),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Offer one item and hold it until the handshake. Valid is never dropped
  // after acceptance here; the next call either keeps it high or opens a gap,
  // so valid gets at most one update per time step.
  task automatic send_item(input logic [7:0] rx, input logic timed_out);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_rx_byte    <= rx;
    in_rx_timeout <= timed_out;
    do @(posedge clk); while (!in_ready);
    sb.accept_transfer(rx, timed_out);
    items_sent++;
  endtask

  // Bytes that are mostly not the handshake, to run up the miss counter.
  task automatic send_noise(input int count);
    logic [7:0] nb;
    repeat (count) begin
      nb = 8'($urandom);
      if (nb == sb.hs_value && $urandom_range(0, 7) != 0)
        nb = ~nb;
      send_item(nb, 1'b0);
    end
  endtask

  // Well-formed packet with random content; cut_at >= 0 replaces that item
  // with a timeout and abandons the rest. Force the wait phase first.
  task automatic send_packet(input logic [7:0] len_byte, input int cut_at);
    int         total;
    logic [7:0] b;
    total = int'(len_byte) + 4;
    if (sb.phase != RX_WAIT)
      send_item(8'($urandom), 1'b1);
    for (int i = 0; i < total; i++) begin
      if (i == cut_at) begin
        send_item(8'($urandom), 1'b1);
        break;
      end
      case (i)
        0:       b = sb.hs_value;
        2:       b = len_byte;
        default: b = 8'($urandom);
      endcase
      send_item(b, 1'b0);
    end
  endtask

  // Drop valid, wait for every predicted reply, then let the pipeline settle.
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Write all registers back to back, plus a stray write past the list.
  // Upper data bits are random so that the field masking is exercised.
  task automatic set_config(input logic [7:0] hs, input logic [4:0] limit,
                            input logic [31:0] seed);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_HANDSHAKE, {junk[31:8], hs});
    junk = $urandom;
    write_reg(REG_MAX_MISS, {junk[31:5], limit});
    write_reg(REG_SEED, seed);
    write_reg(REG_SPARE, $urandom);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold on request so that both
  // pipeline registers fill and in_ready drops while the sender keeps offering.
  initial begin : result_sink
    int holds_served;
    holds_served = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_served < holds_requested) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_served++;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Sample replies at the edge; all drives are nonblocking, so the values
  // seen here are the ones that took part in the handshake.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_reply('{out_tx_next, out_payload_valid, out_payload_byte, out_payload_index,
                       status_t'(out_packet_status), out_packet_length,
                       out_packet_checksum});
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("link_packet_receiver verification failed");
    $finish;
  end

  initial begin : stimulus
    int         phase_end;
    int         next_mix;
    int         pick;
    int         cut;
    logic [7:0] len;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset register values first.
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    // shortest packet, payload all ones
    send_item(HANDSHAKE_RST, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    // two-byte packet, payload zero then top bit only
    send_item(HANDSHAKE_RST, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b0);
    // timeout in the middle of the payload
    send_item(HANDSHAKE_RST, 1'b0);
    send_item(8'h5A, 1'b0);
    send_item(8'h03, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'hFF, 1'b1);
    // timeout while waiting, during the echo and on the length byte
    send_item(8'h00, 1'b1);
    send_item(HANDSHAKE_RST, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(HANDSHAKE_RST, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
    wait_for_replies();
    // a single miss exhausts a limit of one
    set_config(8'hFF, 5'd1, 32'h0000_0000);
    send_item(8'h00, 1'b0);
    wait_for_replies();
    // a limit of zero fails on the first miss; then a packet with an all-ones seed
    set_config(8'h00, 5'd0, 32'hFFFF_FFFF);
    send_item(8'h55, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hAA, 1'b0);

    // Random part: one register setting per phase, extremes first.
    for (int k = 0; k < NUM_PHASES; k++) begin
      wait_for_replies();
      case (k)
        0:       set_config(8'hFF, 5'd31, 32'hFFFF_FFFF);
        1:       set_config(8'h00, 5'd1, 32'h0000_0000);
        4:       set_config(8'($urandom), 5'($urandom_range(0, 31)), $urandom);
        default: set_config(8'($urandom), 5'($urandom_range(1, 31)), $urandom);
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      next_mix  = items_sent;
      if (k == 0)
        send_packet(8'hFF, -1);          // full 256-byte payload
      if (k == 2)
        holds_requested++;
      while (items_sent < phase_end) begin
        // Advance the idling pattern now and then; the last phase runs flat out.
        if (items_sent >= next_mix) begin
          next_mix = items_sent + 40;
          if (k == NUM_PHASES - 1) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
          end else begin
            pick = $urandom_range(0, 2);
            tx_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : 25;
            pick = $urandom_range(0, 2);
            rx_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : 25;
          end
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_noise($urandom_range(0, 2));
          pick = $urandom_range(0, 99);
          if (pick < 80)
            len = 8'($urandom_range(0, 15));
          else if (pick < 95)
            len = 8'($urandom_range(16, 63));
          else
            len = 8'($urandom_range(64, 255));
          cut = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, int'(len) + 3)) : -1;
          send_packet(len, cut);
        end else if (pick < 85) begin
          send_noise($urandom_range(1, 40));
        end else if (pick < 93) begin
          send_item(8'($urandom), 1'b1);
        end else begin
          send_item(8'($urandom), 1'b0);
        end
      end
    end

    wait_for_replies();
    if (sb.mismatches == 0 && sb.replies_due.size() == 0)
      $display("link_packet_receiver verification clean");
    else
      $display("link_packet_receiver verification failed");
    $finish;
  end

endmodule
